@@ rtl/core/ocp_pkg.sv @@
// Orbit camera pose: shared types, constants and the CORDIC arctangent table.
// Used by ocp_cordic and orbit_camera_pose_core; depends on nothing.
package ocp_pkg;

  localparam int CORDIC_STEPS_DEF = 16;

  // Angles in 1/128 degree
  localparam logic signed [17:0] FULL_TURN    = 18'sd46080;
  localparam logic signed [17:0] HALF_TURN    = 18'sd23040;
  localparam logic signed [17:0] QUARTER_TURN = 18'sd11520;

  // CORDIC start value, 0.607252935 in Q2.30
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;

  // Operation codes
  localparam logic [1:0] OP_TURN_H = 2'd0;
  localparam logic [1:0] OP_TURN_V = 2'd1;
  localparam logic [1:0] OP_TOGGLE = 2'd2;
  localparam logic [1:0] OP_LOAD   = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_CENTER_X = 3'd0;
  localparam logic [2:0] CFG_CENTER_Y = 3'd1;
  localparam logic [2:0] CFG_CENTER_Z = 3'd2;
  localparam logic [2:0] CFG_RADIUS   = 3'd3;
  localparam logic [2:0] CFG_ELEV_MAX = 3'd4;
  localparam logic [2:0] CFG_ELEV_MIN = 3'd5;
  localparam logic [2:0] CFG_TOP_ELEV = 3'd6;

  typedef struct packed {
    logic               start;
    logic signed [16:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] sin_q14;
    logic signed [15:0] cos_q14;
  } cordic_rsp_t;

  // atan(2^-i) in degrees, Q16
  function automatic logic [21:0] atan_deg(input logic [4:0] idx);
    logic [21:0] v;
    case (idx)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/ocp_cordic.sv @@
// Rotation-mode CORDIC, one micro-rotation per cycle, giving sine and cosine in Q1.14.
// Depends on ocp_pkg for the request/response structs, gain and arctangent table.
module ocp_cordic
  import ocp_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cordic_req_t req,
  output cordic_rsp_t rsp
);

  localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_RUN  = 2'd1;
  localparam logic [1:0] C_FIN  = 2'd2;

  logic [1:0]         st_r;
  logic [CW-1:0]      it_r;
  logic signed [33:0] x_r, y_r;
  logic signed [25:0] z_r;
  logic               neg_r;
  logic               done_r;
  logic signed [15:0] sin_r, cos_r;

  // angle folding into [-90, 90] degrees
  logic signed [17:0] a0, a1, a2;
  logic               fold_neg;
  logic signed [33:0] dx, dy;
  logic signed [25:0] at;

  always_comb begin
    a0 = {req.angle[16], req.angle};
    if (a0 < 18'sd0) begin
      a0 = a0 + FULL_TURN;
    end
    a1 = (a0 > HALF_TURN) ? a0 - FULL_TURN : a0;
    fold_neg = 1'b0;
    a2 = a1;
    if (a1 > QUARTER_TURN) begin
      a2 = a1 - HALF_TURN;
      fold_neg = 1'b1;
    end else if (a1 < -QUARTER_TURN) begin
      a2 = a1 + HALF_TURN;
      fold_neg = 1'b1;
    end
  end

  assign dx = y_r >>> it_r;
  assign dy = x_r >>> it_r;
  assign at = $signed({4'b0, atan_deg(5'(it_r))});

  function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
    logic signed [33:0] r;
    logic signed [15:0] q;
    r = (v + 34'sd32768) >>> 16;
    if (r > 34'sd16384) begin
      q = 16'sd16384;
    end else if (r < -34'sd16384) begin
      q = -16'sd16384;
    end else begin
      q = r[15:0];
    end
    return q;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= C_IDLE;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= (st_r == C_FIN);
      case (st_r)
        C_IDLE: begin
          if (req.start) begin
            x_r   <= CORDIC_GAIN;
            y_r   <= '0;
            z_r   <= 26'(a2) <<< 9;
            neg_r <= fold_neg;
            it_r  <= '0;
            st_r  <= C_RUN;
          end
        end
        C_RUN: begin
          if (z_r >= 26'sd0) begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            z_r <= z_r - at;
          end else begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            z_r <= z_r + at;
          end
          if (it_r == CW'(CORDIC_STEPS - 1)) begin
            st_r <= C_FIN;
          end else begin
            it_r <= it_r + 1'b1;
          end
        end
        C_FIN: begin
          cos_r  <= to_q14(neg_r ? -x_r : x_r);
          sin_r  <= to_q14(neg_r ? -y_r : y_r);
          st_r   <= C_IDLE;
        end
        default: st_r <= C_IDLE;
      endcase
    end
  end

  assign rsp.done    = done_r;
  assign rsp.sin_q14 = sin_r;
  assign rsp.cos_q14 = cos_r;

endmodule

@@ rtl/core/ocp_mul.sv @@
// Shared signed 32x32 multiplier with a registered 64-bit product.
// Depends on nothing beyond the operands chosen by the sequencer.
module ocp_mul (
  input  logic               clk,
  input  logic signed [31:0] op_a,
  input  logic signed [31:0] op_b,
  output logic signed [63:0] prod
);

  logic signed [63:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule

@@ rtl/core/orbit_camera_pose_core.sv @@
// Orbit camera pose core: pose state, sequencer and output formatting.
// Depends on ocp_pkg, ocp_cordic and ocp_mul.
//
// Input channel (in_valid/in_stall): one operation per transfer - turn
// horizontal, turn vertical, toggle top view or load pose. The core takes
// one item at a time; in_stall is high while an item is in flight.
// Result channel (out_valid/out_stall): one result per item with the camera
// position (Q16.16, saturated), the up vector (Q1.14) and the top-view flag.
// The result comes from two CORDIC runs on the single shared rotation unit,
// azimuth then elevation, followed by a multiply phase on the shared
// multiplier; a horizontal turn or a pose load first wraps the azimuth into
// range. A new item is accepted only after the previous one has finished
// its multiply phase.
// A result held by out_stall stays on the ports unchanged; the next item is
// accepted meanwhile and runs up to its multiply phase, where it waits until
// the held result is taken.
// Configuration (cfg_valid/cfg_ready) is always ready; write only when idle.
// Synchronous reset restores the configuration defaults, clears the pose to
// azimuth 0, elevation 0, top view off, and drops any pending result.
module orbit_camera_pose_core
  import ocp_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic signed [16:0] in_delta_angle,
  input  logic signed [14:0] in_start_elevation,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [15:0] out_up_x,
  output logic signed [15:0] out_up_y,
  output logic signed [15:0] out_up_z,
  output logic               out_top_view_on,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WRAP = 3'd1;
  localparam logic [2:0] S_AZ   = 3'd2;
  localparam logic [2:0] S_AZW  = 3'd3;
  localparam logic [2:0] S_EL   = 3'd4;
  localparam logic [2:0] S_ELW  = 3'd5;
  localparam logic [2:0] S_PEND = 3'd6;
  localparam logic [2:0] S_MUL  = 3'd7;

  // configuration
  logic signed [31:0] center_x_r, center_y_r, center_z_r;
  logic [30:0]        radius_r;
  logic signed [14:0] elev_max_r, elev_min_r, top_elev_r;

  // pose
  logic [15:0]        az_r;
  logic signed [17:0] az_sum_r;
  logic signed [14:0] elev_r, saved_elev_r;
  logic               top_r;

  logic [2:0]         state_r, state_nxt;
  logic [2:0]         mstep_r;
  logic signed [15:0] sa_r, ca_r, se_r, ce_r;
  logic signed [29:0] cc_r, cs_r;

  // result registers
  logic               out_valid_r;
  logic signed [31:0] pos_x_r, pos_y_r, pos_z_r;
  logic signed [15:0] up_x_r, up_y_r, up_z_r;
  logic               top_out_r;

  cordic_req_t        creq;
  cordic_rsp_t        crsp;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;

  logic               in_xfer;
  logic signed [17:0] e_sum, e_hi;
  logic signed [14:0] elev_turn;
  logic signed [16:0] up_rnd;
  logic signed [15:0] up_neg;

  ocp_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (creq),
    .rsp  (crsp)
  );

  ocp_mul u_mul (
    .clk (clk),
    .op_a(mul_a),
    .op_b(mul_b),
    .prod(prod)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // vertical turn: clamp to the upper limit first, then to the lower one
  always_comb begin
    e_sum = {{3{elev_r[14]}}, elev_r} + {in_delta_angle[16], in_delta_angle};
    e_hi  = (e_sum > 18'(elev_max_r)) ? 18'(elev_max_r) : e_sum;
    elev_turn = (e_hi < 18'(elev_min_r)) ? elev_min_r : e_hi[14:0];
  end

  always_comb begin
    creq.start = (state_r == S_AZ) || (state_r == S_EL);
    creq.angle = (state_r == S_AZ) ? $signed({1'b0, az_r}) : 17'(elev_r);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (mstep_r)
      3'd0: begin mul_a = 32'(ce_r); mul_b = 32'(ca_r); end
      3'd1: begin mul_a = 32'(ce_r); mul_b = 32'(sa_r); end
      3'd2: begin mul_a = 32'(se_r); mul_b = 32'(ca_r); end
      3'd3: begin mul_a = 32'(se_r); mul_b = 32'(sa_r); end
      3'd4: begin mul_a = $signed({1'b0, radius_r}); mul_b = 32'(se_r); end
      3'd5: begin mul_a = $signed({1'b0, radius_r}); mul_b = 32'(cc_r); end
      3'd6: begin mul_a = $signed({1'b0, radius_r}); mul_b = 32'(cs_r); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // up component: round the Q2.28 product half up to Q1.14, then negate
  always_comb begin
    up_rnd = $signed(prod[30:14]) + $signed({16'd0, prod[13]});
    up_neg = 16'(17'sd0 - up_rnd);
  end

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] c,
                                                 input logic signed [34:0] p,
                                                 input logic               rnd);
    logic signed [36:0] s;
    logic signed [31:0] q;
    s = 37'(c) + 37'(p) + $signed({36'd0, rnd});
    if (s > 37'sd2147483647) begin
      q = 32'sh7fffffff;
    end else if (s < -37'sd2147483648) begin
      q = 32'sh80000000;
    end else begin
      q = s[31:0];
    end
    return q;
  endfunction

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = ((in_operation == OP_TURN_H) || (in_operation == OP_LOAD)) ?
                      S_WRAP : S_AZ;
        end
      end
      S_WRAP: begin
        if ((az_sum_r >= 18'sd0) && (az_sum_r < FULL_TURN)) begin
          state_nxt = S_AZ;
        end
      end
      S_AZ:   state_nxt = S_AZW;
      S_AZW:  if (crsp.done) state_nxt = S_EL;
      S_EL:   state_nxt = S_ELW;
      S_ELW:  if (crsp.done) state_nxt = S_PEND;
      S_PEND: if (!out_valid_r) state_nxt = S_MUL;
      S_MUL:  if (mstep_r == 3'd7) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mstep_r      <= '0;
      out_valid_r  <= 1'b0;
      az_r         <= '0;
      elev_r       <= '0;
      saved_elev_r <= '0;
      top_r        <= 1'b0;
      center_x_r   <= '0;
      center_y_r   <= '0;
      center_z_r   <= '0;
      radius_r     <= 31'd655360;
      elev_max_r   <= 15'sd11392;
      elev_min_r   <= -15'sd11392;
      top_elev_r   <= 15'sd11520;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CENTER_X: center_x_r <= cfg_data;
          CFG_CENTER_Y: center_y_r <= cfg_data;
          CFG_CENTER_Z: center_z_r <= cfg_data;
          CFG_RADIUS:   radius_r   <= cfg_data[30:0];
          CFG_ELEV_MAX: elev_max_r <= cfg_data[14:0];
          CFG_ELEV_MIN: elev_min_r <= cfg_data[14:0];
          CFG_TOP_ELEV: top_elev_r <= cfg_data[14:0];
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            case (in_operation)
              OP_TURN_H: begin
                az_sum_r <= $signed({2'b0, az_r}) + {in_delta_angle[16], in_delta_angle};
              end
              OP_TURN_V: begin
                if (!top_r) begin
                  elev_r <= elev_turn;
                end
              end
              OP_TOGGLE: begin
                if (top_r) begin
                  elev_r <= saved_elev_r;
                  top_r  <= 1'b0;
                end else begin
                  saved_elev_r <= elev_r;
                  elev_r       <= top_elev_r;
                  top_r        <= 1'b1;
                end
              end
              OP_LOAD: begin
                az_sum_r <= {in_delta_angle[16], in_delta_angle};
                elev_r   <= in_start_elevation;
                top_r    <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_WRAP: begin
          // one correction by a full turn per cycle
          if (az_sum_r < 18'sd0) begin
            az_sum_r <= az_sum_r + FULL_TURN;
          end else if (az_sum_r >= FULL_TURN) begin
            az_sum_r <= az_sum_r - FULL_TURN;
          end else begin
            az_r <= az_sum_r[15:0];
          end
        end
        S_AZW: begin
          if (crsp.done) begin
            sa_r <= crsp.sin_q14;
            ca_r <= crsp.cos_q14;
          end
        end
        S_ELW: begin
          if (crsp.done) begin
            se_r <= crsp.sin_q14;
            ce_r <= crsp.cos_q14;
          end
          mstep_r <= '0;
        end
        S_MUL: begin
          mstep_r <= mstep_r + 1'b1;
          // post-process the product of the previous step
          case (mstep_r)
            3'd1: cc_r   <= prod[29:0];
            3'd2: cs_r   <= prod[29:0];
            3'd3: up_x_r <= up_neg;
            3'd4: up_z_r <= up_neg;
            3'd5: pos_y_r <= sat_add(center_y_r, 35'($signed(prod[47:14])), prod[13]);
            3'd6: pos_x_r <= sat_add(center_x_r, $signed(prod[62:28]), prod[27]);
            3'd7: begin
              pos_z_r     <= sat_add(center_z_r, $signed(prod[62:28]), prod[27]);
              up_y_r      <= ce_r;
              top_out_r   <= top_r;
              out_valid_r <= 1'b1;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pos_x       = pos_x_r;
  assign out_pos_y       = pos_y_r;
  assign out_pos_z       = pos_z_r;
  assign out_up_x        = up_x_r;
  assign out_up_y        = up_y_r;
  assign out_up_z        = up_z_r;
  assign out_top_view_on = top_out_r;

endmodule

@@ rtl/core/ocp_checker.sv @@
// Port-level checks for the orbit camera pose core, bound to the top level.
// Depends only on the ports of orbit_camera_pose_core.
module ocp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_pos_x,
  input logic signed [15:0] out_up_y
);

  // a held result stays valid, with out_pos_x unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pos_x))
    else $error("held result changed");

  // one item at a time: busy right after an input transfer
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  // reset drops any pending result
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // cosine of the elevation stays within unit range
  a_up_y_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_up_y >= -16'sd16384) && (out_up_y <= 16'sd16384))
    else $error("up_y out of range");

endmodule

bind orbit_camera_pose_core ocp_checker u_ocp_checker (.*);
